// ===== src/pfde_pkg.sv =====
// Shared types, constants and 5x5 cell helpers for the Playfair digraph encryptor.
// No dependencies.
package pfde_pkg;

    localparam logic [4:0] FILLER_LETTER = 5'd23;
    localparam logic [4:0] ALPHABET_SIZE = 5'd26;
    localparam logic [4:0] TABLE_CELLS   = 5'd25;

    // Configuration register indexes
    localparam logic CFG_DROP  = 1'b0;
    localparam logic CFG_MERGE = 1'b1;

    typedef enum logic [1:0] {
        MODE_KEY      = 2'd0,
        MODE_KEY_DONE = 2'd1,
        MODE_MSG      = 2'd2,
        MODE_MSG_END  = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILL = 5'b00010,
        ST_CALC = 5'b00100,
        ST_OUT1 = 5'b01000,
        ST_OUT2 = 5'b10000
    } state_t;

    // Row of a cell index 0..24
    function automatic logic [2:0] pos_row(input logic [4:0] p);
        logic [2:0] r;
        if (p >= 5'd20) begin
            r = 3'd4;
        end else if (p >= 5'd15) begin
            r = 3'd3;
        end else if (p >= 5'd10) begin
            r = 3'd2;
        end else if (p >= 5'd5) begin
            r = 3'd1;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    // Column of a cell index 0..24
    function automatic logic [2:0] pos_col(input logic [4:0] p);
        logic [2:0] r;
        logic [4:0] base;
        r    = pos_row(p);
        base = 5'({r, 2'b00}) + 5'(r);
        return 3'(p - base);
    endfunction

    // Cell index from row and column
    function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        return 5'({r, 2'b00}) + 5'(r) + 5'(c);
    endfunction

    // Step to the next row or column, wrapping after four
    function automatic logic [2:0] wrap_inc(input logic [2:0] v);
        return (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
    endfunction

endpackage

// ===== src/playfair_digraph_encryptor.sv =====
// Playfair digraph encryptor top level: key table build, pairing and pair encryption.
// Depends on pfde_pkg; holds the cipher table and letter position memories.
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+------------------------
//  input     | s_mode, s_letter                    | s_valid / s_ready
//  result    | m_cipher_letter, m_last             | m_valid / m_ready
//  config    | cfg_index, cfg_wdata                | cfg_we, no wait
//
//  Key letters and unpaired message letters are taken in ST_IDLE and leave s_ready high.
//  A message item that completes a pair goes through the position read, the table read,
//  then one result letter each in ST_OUT1 and ST_OUT2, each held until m_ready.
//  Key finished walks the alphabet through the table write port.
//  Reset clears counters and the used-letter mask; memories are filled by the key.
//  While a result waits on m_ready, s_ready stays low.
module playfair_digraph_encryptor
    import pfde_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [4:0] s_letter,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_cipher_letter,
    output logic       m_last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [4:0] cfg_wdata
);

    state_t      state_reg, state_next;
    logic [4:0]  drop_reg, merge_reg;
    logic [25:0] used_reg, used_next;
    logic [4:0]  fill_count_reg, fill_count_next;
    logic        complete_reg, complete_next;
    logic [4:0]  held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [4:0]  sweep_reg, sweep_next;

    logic [4:0]  cipher_table_mem [TABLE_CELLS];
    logic [4:0]  letter_position_mem [ALPHABET_SIZE];
    logic [4:0]  pa_reg, pb_reg;
    logic [4:0]  ca_reg, cb_reg;

    logic        accept;
    logic [4:0]  letter_sub, filler_sub;
    logic [31:0] used_ext;
    logic        letter_in_tab, filler_in_tab;
    logic [4:0]  app_letter;
    logic        app_req, app_en;
    logic        pair_go;
    logic [4:0]  pair_b;
    logic [2:0]  r1, c1, r2, c2;
    logic [4:0]  o1, o2;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // Replace the dropped letter and look up table membership
    assign letter_sub    = (s_letter == drop_reg) ? merge_reg : s_letter;
    assign filler_sub    = (FILLER_LETTER == drop_reg) ? merge_reg : FILLER_LETTER;
    assign used_ext      = {6'b0, used_reg};
    assign letter_in_tab = (letter_sub < ALPHABET_SIZE) && used_ext[letter_sub];
    assign filler_in_tab = (filler_sub < ALPHABET_SIZE) && used_ext[filler_sub];

    // Share one append path between key letters and the alphabet sweep
    assign app_letter = (state_reg == ST_FILL) ? sweep_reg : letter_sub;
    assign app_req    = ((state_reg == ST_FILL) && (sweep_reg != drop_reg))
                     || (accept && (s_mode == MODE_KEY) && !complete_reg);
    assign app_en     = app_req && (app_letter < ALPHABET_SIZE)
                     && (fill_count_reg < TABLE_CELLS) && !used_ext[app_letter];

    // Sequence key, pairing and output steps
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        fill_count_next = fill_count_reg;
        complete_next   = complete_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        sweep_next      = sweep_reg;
        pair_go         = 1'b0;
        pair_b          = letter_sub;

        if (app_en) begin
            used_next       = used_reg | (26'd1 << app_letter);
            fill_count_next = 5'(fill_count_reg + 5'd1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_KEY_DONE: begin
                            if (!complete_reg) begin
                                sweep_next = 5'd0;
                                state_next = ST_FILL;
                            end
                        end
                        MODE_MSG: begin
                            if (complete_reg && letter_in_tab) begin
                                if (!held_valid_reg) begin
                                    held_next       = letter_sub;
                                    held_valid_next = 1'b1;
                                end else if (held_reg != letter_sub) begin
                                    held_valid_next = 1'b0;
                                    pair_go         = 1'b1;
                                end else if (filler_in_tab) begin
                                    pair_b    = filler_sub;
                                    held_next = letter_sub;
                                    pair_go   = 1'b1;
                                end
                            end
                        end
                        MODE_MSG_END: begin
                            if (complete_reg && held_valid_reg && filler_in_tab) begin
                                pair_b          = filler_sub;
                                held_valid_next = 1'b0;
                                pair_go         = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (pair_go) begin
                        state_next = ST_CALC;
                    end
                end
            end
            ST_FILL: begin
                sweep_next = 5'(sweep_reg + 5'd1);
                if (sweep_reg == ALPHABET_SIZE - 5'd1) begin
                    complete_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CALC: begin
                state_next = ST_OUT1;
            end
            ST_OUT1: begin
                if (m_ready) begin
                    state_next = ST_OUT2;
                end
            end
            ST_OUT2: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            drop_reg       <= 5'd9;
            merge_reg      <= 5'd8;
            used_reg       <= '0;
            fill_count_reg <= '0;
            complete_reg   <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            sweep_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            fill_count_reg <= fill_count_next;
            complete_reg   <= complete_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            sweep_reg      <= sweep_next;
            if (cfg_we) begin
                if (cfg_index == CFG_DROP) begin
                    drop_reg <= cfg_wdata;
                end else begin
                    merge_reg <= cfg_wdata;
                end
            end
        end
    end

    // Write the position memory on append; read both pair positions when the pair starts.
    // Writes happen only before the table is complete and reads only after, so no overlap.
    always_ff @(posedge aclk) begin
        if (app_en) begin
            letter_position_mem[app_letter] <= fill_count_reg;
        end
        if (pair_go) begin
            pa_reg <= letter_position_mem[held_reg];
            pb_reg <= letter_position_mem[pair_b];
        end
    end

    // Apply the Playfair rules to the two positions
    assign r1 = pos_row(pa_reg);
    assign c1 = pos_col(pa_reg);
    assign r2 = pos_row(pb_reg);
    assign c2 = pos_col(pb_reg);

    always_comb begin
        if (r1 == r2) begin
            o1 = cell_of(r1, wrap_inc(c1));
            o2 = cell_of(r2, wrap_inc(c2));
        end else if (c1 == c2) begin
            o1 = cell_of(wrap_inc(r1), c1);
            o2 = cell_of(wrap_inc(r2), c2);
        end else begin
            o1 = cell_of(r1, c2);
            o2 = cell_of(r2, c1);
        end
    end

    // Write the table on append; read both cipher letters in the calc step
    always_ff @(posedge aclk) begin
        if (app_en) begin
            cipher_table_mem[fill_count_reg] <= app_letter;
        end
        if (state_reg == ST_CALC) begin
            ca_reg <= cipher_table_mem[o1];
            cb_reg <= cipher_table_mem[o2];
        end
    end

    // Present the two result items in turn
    assign m_valid         = (state_reg == ST_OUT1) || (state_reg == ST_OUT2);
    assign m_last          = (state_reg == ST_OUT2);
    assign m_cipher_letter = (state_reg == ST_OUT2) ? cb_reg : ca_reg;

    // Each table entry maps to exactly one used letter
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == 32'(fill_count_reg))
        else $error("used-letter mask and fill count disagree");

    // Finishing the key always leaves a full table
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(complete_reg) |-> fill_count_reg == TABLE_CELLS)
        else $error("table completed without 25 cells");

    // Results and held letters appear only after the table is complete
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid || held_valid_reg) |-> complete_reg)
        else $error("message activity before table complete");

    // The second letter of a pair closes the item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT2 && m_ready) |=> state_reg == ST_IDLE)
        else $error("pair output did not return to idle");

endmodule
